@@ hdl/cau_pkg.sv @@
// shared types, constants and helper functions of the complex arithmetic unit
// no dependencies; every other file of the unit imports this package

package cau_pkg;

	localparam int IO_W    = 32;            // port width of each operand part
	localparam int DW      = 32;            // internal signed data width
	localparam int FB      = 16;            // fraction bits
	localparam int PW      = 2 * DW;        // full product width
	localparam int DIV_SH  = DW - FB;       // dividend bits above the quotient window
	localparam int CX_W    = 52;            // cordic x/y width
	localparam int CZ_W    = 34;            // cordic angle width, q30
	localparam int CPRE    = 16;            // cordic input prescale
	localparam int N_STEPS = 32;            // iteration stages
	localparam int STEP_W  = $clog2(N_STEPS);

	localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = CZ_W'(1686629713);

	localparam logic [PW:0] SAT_LIM    = (PW+1)'(1) << (DW - 1);
	localparam logic [PW:0] SAT_MAXMAG = SAT_LIM - 1'b1;
	localparam logic [DW-1:0] MIN_VAL  = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] MAX_VAL  = {1'b0, {(DW-1){1'b1}}};

	typedef enum logic [2:0] {
		ACT_ADD,
		ACT_SUB,
		ACT_MUL,
		ACT_DIV,
		ACT_MOD,
		ACT_ARG,
		ACT_CONJ,
		ACT_NONE
	} cau_action_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_DIV0,
		ST_SAT,
		ST_ARG_UNDEF
	} cau_status_t;

	typedef struct packed {
		cau_action_t        action;
		logic signed [IO_W-1:0] a_re;
		logic signed [IO_W-1:0] a_im;
		logic signed [IO_W-1:0] b_re;
		logic signed [IO_W-1:0] b_im;
	} cau_req_t;

	typedef struct packed {
		logic signed [IO_W-1:0] res_re;
		logic signed [IO_W-1:0] res_im;
		cau_status_t            status;
	} cau_rsp_t;

	typedef struct packed {
		logic          sat;
		logic [DW-1:0] val;
	} cau_sat_t;

	// per-request control carried alongside the iteration stages
	typedef struct packed {
		cau_action_t   action;
		logic [DW-1:0] early_re;
		logic [DW-1:0] early_im;
		logic          early_sat;
		logic          den_zero;
		logic          arg_re0;
		logic          arg_pos;
		logic          arg_zero;
	} cau_tag_t;

	typedef struct packed {
		logic          neg;
		logic          big;
		logic [PW-1:0] rem;
		logic [DW-1:0] q;
		logic [DW-1:0] low;
	} cau_div_t;

	typedef struct packed {
		logic [PW-1:0] rad;
		logic [DW:0]   rem;
		logic [DW-1:0] root;
	} cau_sqrt_t;

	typedef struct packed {
		logic signed [CX_W-1:0] x;
		logic signed [CX_W-1:0] y;
		logic signed [CZ_W-1:0] z;
	} cau_cordic_t;

	typedef struct packed {
		cau_tag_t      tag;
		logic [PW-1:0] den;
		cau_div_t      dre;
		cau_div_t      dim;
		cau_sqrt_t     sq;
		cau_cordic_t   cor;
	} cau_work_t;

	// clamp a sign-magnitude value to the signed data range
	function automatic cau_sat_t cau_sat_sm(input logic neg, input logic [PW:0] mag);
		cau_sat_t r;
		r.sat = 1'b0;
		if (neg) begin
			if (mag > SAT_LIM) begin
				r.sat = 1'b1;
				r.val = MIN_VAL;
			end else begin
				r.val = (~mag[DW-1:0]) + 1'b1;
			end
		end else begin
			if (mag > SAT_MAXMAG) begin
				r.sat = 1'b1;
				r.val = MAX_VAL;
			end else begin
				r.val = mag[DW-1:0];
			end
		end
		return r;
	endfunction

	// clamp a one-bit-wider two's complement value
	function automatic cau_sat_t cau_sat_int(input logic [DW:0] s);
		cau_sat_t r;
		r.sat = s[DW] ^ s[DW-1];
		if (r.sat) begin
			r.val = s[DW] ? MIN_VAL : MAX_VAL;
		end else begin
			r.val = s[DW-1:0];
		end
		return r;
	endfunction

	// atan(2^-i) in q30
	function automatic logic signed [CZ_W-1:0] cau_atan(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return CZ_W'(v);
	endfunction

endpackage

@@ hdl/cau_front.sv @@
// front end: operand register, products, sums, sign-magnitude and iteration setup
// depends on cau_pkg

module cau_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cau_pkg::cau_req_t req,
	output logic              vld,
	output cau_pkg::cau_work_t work
);
	import cau_pkg::*;

	localparam logic [PW:0] MUL_HALF = (PW+1)'(1) << (FB - 1);

	typedef struct packed {
		cau_action_t            action;
		cau_sat_t               s_re;
		cau_sat_t               s_im;
		logic signed [CX_W-1:0] cx;
		logic signed [CX_W-1:0] cy;
		logic                   re0;
		logic                   pos;
		logic                   azero;
	} carry_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	cau_req_t req_s1;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	carry_t car_s2, car_s3, car_s4;
	logic [PW:0] nr_s3, ni_s3;
	logic [PW-1:0] den_s3, den_s4;
	logic nr_neg_s4, ni_neg_s4, den_zero_s4;
	logic [PW-1:0] nr_mag_s4, ni_mag_s4;
	cau_work_t work_s5;

	logic signed [DW-1:0] ar, ai, br, bi, sx, sy;
	logic [DW:0] add_re, add_im, sub_re, sub_im, neg_ai, abs_ar, yv;
	carry_t car_d;
	logic [PW:0] nr_abs, ni_abs;
	cau_work_t work_d;
	cau_sat_t mul_re, mul_im;

	function automatic cau_div_t div_init(input logic neg, input logic [PW-1:0] n,
			input logic [PW-1:0] den);
		cau_div_t r;
		r.neg = neg;
		// quotient needs more than DW bits: saturates whatever the sign
		r.big = {{DIV_SH{1'b0}}, n} >= {den, {DIV_SH{1'b0}}};
		r.rem = n >> DIV_SH;
		r.q   = '0;
		r.low = {n[DIV_SH-1:0], {FB{1'b0}}};
		return r;
	endfunction

	function automatic cau_sat_t round_frac(input logic neg, input logic [PW-1:0] mag);
		logic [PW:0] t;
		t = {1'b0, mag} + MUL_HALF;
		return cau_sat_sm(neg, t >> FB);
	endfunction

	// stage 2 logic
	always_comb begin
		ar = req_s1.a_re[DW-1:0];
		ai = req_s1.a_im[DW-1:0];
		br = req_s1.b_re[DW-1:0];
		bi = req_s1.b_im[DW-1:0];
		sx = (req_s1.action == ACT_DIV) ? br : ar;
		sy = (req_s1.action == ACT_DIV) ? bi : ai;
		add_re = {ar[DW-1], ar} + {br[DW-1], br};
		add_im = {ai[DW-1], ai} + {bi[DW-1], bi};
		sub_re = {ar[DW-1], ar} - {br[DW-1], br};
		sub_im = {ai[DW-1], ai} - {bi[DW-1], bi};
		neg_ai = (DW+1)'(0) - {ai[DW-1], ai};
		abs_ar = ar[DW-1] ? (DW+1)'(0) - {ar[DW-1], ar} : {1'b0, ar};
		yv     = ar[DW-1] ? neg_ai : {ai[DW-1], ai};

		car_d.action = req_s1.action;
		car_d.s_re   = '0;
		car_d.s_im   = '0;
		unique case (req_s1.action)
			ACT_ADD: begin
				car_d.s_re = cau_sat_int(add_re);
				car_d.s_im = cau_sat_int(add_im);
			end
			ACT_SUB: begin
				car_d.s_re = cau_sat_int(sub_re);
				car_d.s_im = cau_sat_int(sub_im);
			end
			ACT_CONJ: begin
				car_d.s_re.val = ar;
				car_d.s_im     = cau_sat_int(neg_ai);
			end
			default: begin
				car_d.s_re = '0;
			end
		endcase
		car_d.cx    = {{(CX_W-DW-1-CPRE){1'b0}}, abs_ar, {CPRE{1'b0}}};
		car_d.cy    = {{(CX_W-DW-1-CPRE){yv[DW]}}, yv, {CPRE{1'b0}}};
		car_d.re0   = (ar == '0);
		car_d.pos   = !ai[DW-1] && (ai != '0);
		car_d.azero = (ar == '0) && (ai == '0);
	end

	// stage 4 logic
	always_comb begin
		nr_abs = nr_s3[PW] ? (~nr_s3 + 1'b1) : nr_s3;
		ni_abs = ni_s3[PW] ? (~ni_s3 + 1'b1) : ni_s3;
	end

	// stage 5 logic
	always_comb begin
		mul_re = round_frac(nr_neg_s4, nr_mag_s4);
		mul_im = round_frac(ni_neg_s4, ni_mag_s4);

		work_d.tag.action    = car_s4.action;
		work_d.tag.early_re  = car_s4.s_re.val;
		work_d.tag.early_im  = car_s4.s_im.val;
		work_d.tag.early_sat = car_s4.s_re.sat | car_s4.s_im.sat;
		if (car_s4.action == ACT_MUL) begin
			work_d.tag.early_re  = mul_re.val;
			work_d.tag.early_im  = mul_im.val;
			work_d.tag.early_sat = mul_re.sat | mul_im.sat;
		end
		work_d.tag.den_zero = den_zero_s4;
		work_d.tag.arg_re0  = car_s4.re0;
		work_d.tag.arg_pos  = car_s4.pos;
		work_d.tag.arg_zero = car_s4.azero;
		work_d.den     = den_s4;
		work_d.dre     = div_init(nr_neg_s4, nr_mag_s4, den_s4);
		work_d.dim     = div_init(ni_neg_s4, ni_mag_s4, den_s4);
		work_d.sq.rad  = den_s4;
		work_d.sq.rem  = '0;
		work_d.sq.root = '0;
		work_d.cor.x   = car_s4.cx;
		work_d.cor.y   = car_s4.cy;
		work_d.cor.z   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= req;

		p0_s2  <= ar * br;
		p1_s2  <= ai * bi;
		p2_s2  <= ar * bi;
		p3_s2  <= ai * br;
		p4_s2  <= sx * sx;
		p5_s2  <= sy * sy;
		car_s2 <= car_d;

		if (car_s2.action == ACT_MUL) begin
			nr_s3 <= {p0_s2[PW-1], p0_s2} - {p1_s2[PW-1], p1_s2};
			ni_s3 <= {p2_s2[PW-1], p2_s2} + {p3_s2[PW-1], p3_s2};
		end else begin
			nr_s3 <= {p0_s2[PW-1], p0_s2} + {p1_s2[PW-1], p1_s2};
			ni_s3 <= {p3_s2[PW-1], p3_s2} - {p2_s2[PW-1], p2_s2};
		end
		den_s3 <= $unsigned(p4_s2) + $unsigned(p5_s2);
		car_s3 <= car_s2;

		nr_neg_s4   <= nr_s3[PW];
		ni_neg_s4   <= ni_s3[PW];
		nr_mag_s4   <= nr_abs[PW-1:0];
		ni_mag_s4   <= ni_abs[PW-1:0];
		den_s4      <= den_s3;
		den_zero_s4 <= (den_s3 == '0);
		car_s4      <= car_s3;

		work_s5 <= work_d;
	end

	assign vld  = v_s5;
	assign work = work_s5;

endmodule

@@ hdl/cau_step.sv @@
// one iteration stage: restoring divide step on both parts, square root step
// and cordic vectoring step; depends on cau_pkg

module cau_step #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               prev_vld,
	input  cau_pkg::cau_work_t prev_work,
	output logic               next_vld,
	output cau_pkg::cau_work_t next_work
);
	import cau_pkg::*;

	localparam logic signed [CZ_W-1:0] ANGLE = cau_atan(STEP_W'(STEP));

	logic      v_s1;
	cau_work_t work_s1;
	cau_work_t work_d;
	logic [DW+2:0] sq_rem2, sq_trial, sq_diff;
	logic sq_take;
	logic signed [CX_W-1:0] dx, dy;

	function automatic cau_div_t div_step(input cau_div_t l, input logic [PW-1:0] den);
		cau_div_t r;
		logic [PW:0] rem2;
		logic [PW:0] diff;
		logic take;
		rem2 = {l.rem, l.low[DW-1]};
		diff = rem2 - {1'b0, den};
		take = (rem2 >= {1'b0, den});
		r = l;
		r.rem = take ? diff[PW-1:0] : rem2[PW-1:0];
		r.q   = {l.q[DW-2:0], take};
		r.low = {l.low[DW-2:0], 1'b0};
		return r;
	endfunction

	always_comb begin
		work_d     = prev_work;
		work_d.dre = div_step(prev_work.dre, prev_work.den);
		work_d.dim = div_step(prev_work.dim, prev_work.den);

		// two radicand bits per step
		sq_rem2  = {prev_work.sq.rem, prev_work.sq.rad[PW-1 -: 2]};
		sq_trial = {1'b0, prev_work.sq.root, 2'b01};
		sq_diff  = sq_rem2 - sq_trial;
		sq_take  = (sq_rem2 >= sq_trial);
		work_d.sq.rem  = sq_take ? sq_diff[DW:0] : sq_rem2[DW:0];
		work_d.sq.root = {prev_work.sq.root[DW-2:0], sq_take};
		work_d.sq.rad  = {prev_work.sq.rad[PW-3:0], 2'b00};

		dx = prev_work.cor.y >>> STEP;
		dy = prev_work.cor.x >>> STEP;
		if (!prev_work.cor.y[CX_W-1]) begin
			work_d.cor.x = prev_work.cor.x + dx;
			work_d.cor.y = prev_work.cor.y - dy;
			work_d.cor.z = prev_work.cor.z + ANGLE;
		end else begin
			work_d.cor.x = prev_work.cor.x - dx;
			work_d.cor.y = prev_work.cor.y + dy;
			work_d.cor.z = prev_work.cor.z - ANGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		work_s1 <= work_d;
	end

	assign next_vld  = v_s1;
	assign next_work = work_s1;

endmodule

@@ hdl/cau_back.sv @@
// back end: quotient, root and angle rounding, then saturation, result
// select and status; depends on cau_pkg

module cau_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld,
	input  cau_pkg::cau_work_t work,
	output logic               done,
	output cau_pkg::cau_rsp_t  rsp
);
	import cau_pkg::*;

	localparam logic [CZ_W:0] ARG_HALF = (CZ_W+1)'(1) << (29 - FB);

	typedef struct packed {
		logic        neg;
		logic        big;
		logic [DW:0] mag;
	} quo_t;

	logic     v_s1, v_s2;
	cau_tag_t tag_s1;
	quo_t     qre_s1, qim_s1;
	logic [DW:0] sq_mag_s1;
	logic     arg_neg_s1;
	logic [CZ_W:0] arg_mag_s1;
	cau_rsp_t rsp_s2;

	logic [DW:0] sq_mag;
	logic signed [CZ_W-1:0] zsel;
	logic [CZ_W-1:0] zabs;
	logic [CZ_W:0] arg_mag;
	cau_sat_t fre, fim;
	cau_status_t st;

	function automatic quo_t quo_round(input cau_div_t l, input logic [PW-1:0] den);
		quo_t r;
		logic up;
		up    = ({l.rem, 1'b0} >= {1'b0, den});
		r.neg = l.neg;
		r.big = l.big;
		r.mag = {1'b0, l.q} + up;
		return r;
	endfunction

	function automatic cau_sat_t quo_sat(input quo_t v);
		logic [PW:0] m;
		m = v.big ? (SAT_LIM << 1) : (PW+1)'(v.mag);
		return cau_sat_sm(v.neg, m);
	endfunction

	always_comb begin
		sq_mag = {1'b0, work.sq.root} + (work.sq.rem > {1'b0, work.sq.root});
		if (work.tag.arg_re0) begin
			zsel = work.tag.arg_pos ? HALF_PI_Q30 : -HALF_PI_Q30;
		end else begin
			zsel = work.cor.z;
		end
		zabs    = zsel[CZ_W-1] ? (~zsel + 1'b1) : zsel;
		arg_mag = ({1'b0, zabs} + ARG_HALF) >> (30 - FB);
	end

	always_comb begin
		fre = '0;
		fim = '0;
		st  = ST_OK;
		unique case (tag_s1.action)
			ACT_DIV: begin
				if (tag_s1.den_zero) begin
					st = ST_DIV0;
				end else begin
					fre = quo_sat(qre_s1);
					fim = quo_sat(qim_s1);
				end
			end
			ACT_MOD: begin
				fre = cau_sat_sm(1'b0, (PW+1)'(sq_mag_s1));
			end
			ACT_ARG: begin
				if (tag_s1.arg_zero) begin
					st = ST_ARG_UNDEF;
				end else begin
					fre = cau_sat_sm(arg_neg_s1, (PW+1)'(arg_mag_s1));
				end
			end
			default: begin
				fre.val = tag_s1.early_re;
				fim.val = tag_s1.early_im;
				fre.sat = tag_s1.early_sat;
			end
		endcase
		if (st == ST_OK && (fre.sat || fim.sat)) begin
			st = ST_SAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= vld;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1     <= work.tag;
		qre_s1     <= quo_round(work.dre, work.den);
		qim_s1     <= quo_round(work.dim, work.den);
		sq_mag_s1  <= sq_mag;
		arg_neg_s1 <= zsel[CZ_W-1];
		arg_mag_s1 <= arg_mag;

		rsp_s2.res_re <= IO_W'($signed(fre.val));
		rsp_s2.res_im <= IO_W'($signed(fim.val));
		rsp_s2.status <= st;
	end

	assign done = v_s2;
	assign rsp  = rsp_s2;

endmodule

@@ hdl/complex_arithmetic_unit.sv @@
// top level of the complex arithmetic unit: front end, iteration stages, back end
// depends on cau_pkg, cau_front, cau_step, cau_back

// Signed Q16.16 complex arithmetic (add, subtract, multiply, divide, modulus,
// argument, conjugate) as a fully pipelined unit. A request is taken on every
// clock edge where start is high; busy is always low, so one request per cycle
// is sustained. Each request gives exactly one result on rsp, marked by done
// for one cycle, in request order. The result must be captured in that cycle.
// The pipeline is made of five front-end stages (operand register,
// multipliers, sums, sign-magnitude, setup), 32 iteration stages that each
// retire one quotient bit per part, one root bit and one cordic rotation,
// and two stages of rounding and saturation.

module complex_arithmetic_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cau_pkg::cau_req_t req,
	output logic              done,
	output cau_pkg::cau_rsp_t rsp
);
	import cau_pkg::*;

	logic      vld_chain  [0:N_STEPS];
	cau_work_t work_chain [0:N_STEPS];

	assign busy = 1'b0;

	cau_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.vld    (vld_chain[0]),
		.work   (work_chain[0])
	);

	for (genvar i = 0; i < N_STEPS; i++) begin : g_step
		cau_step #(
			.STEP (i)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.prev_vld  (vld_chain[i]),
			.prev_work (work_chain[i]),
			.next_vld  (vld_chain[i+1]),
			.next_work (work_chain[i+1])
		);
	end

	cau_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_chain[N_STEPS]),
		.work   (work_chain[N_STEPS]),
		.done   (done),
		.rsp    (rsp)
	);

endmodule
